// ===== hw/rtl/epd_pkg.sv =====
// ----------------------------------------------------------------------------
// epd_pkg
// Types, constants and the byte-wide CRC-32 update shared by the escaped
// packet deframer.
// ----------------------------------------------------------------------------
package epd_pkg;

	localparam logic [7:0]  ESC_BYTE     = 8'hAA;
	localparam logic [7:0]  END_BYTE     = 8'hFF;
	localparam logic [9:0]  CRC_LEN      = 10'd4;
	localparam logic [10:0] LEN_CAP      = 11'd1023;
	localparam logic [9:0]  MAX_LEN_RST  = 10'd249;
	localparam logic [31:0] CRC_POLY     = 32'hEDB88320;
	localparam logic [31:0] CRC_INIT     = 32'hFFFFFFFF;
	localparam logic [15:0] REJECT_MAX   = 16'hFFFF;

	typedef enum logic [1:0] {
		PH_HUNT = 2'd0,
		PH_ESC  = 2'd1,
		PH_DATA = 2'd2
	} phase_t;

	typedef enum logic [2:0] {
		EV_GOOD      = 3'd0,
		EV_CRC_BAD   = 3'd1,
		EV_TOO_SHORT = 3'd2,
		EV_TOO_LONG  = 3'd3,
		EV_END_MARK  = 3'd4
	} event_code_t;

	typedef struct packed {
		phase_t      phase;
		logic [7:0]  mask;
		logic [9:0]  bytes_seen;
		logic [31:0] tail;
		logic [31:0] crc;
		logic [15:0] reject;
	} state_t;

	typedef struct packed {
		logic        byte_valid;
		logic [7:0]  out_byte;
		logic        event_valid;
		event_code_t event_code;
		logic [15:0] bad_packet_count;
	} result_t;

	// Reflected CRC-32, one byte in, eight shift steps unrolled to an XOR tree
	function automatic logic [31:0] crc_byte(input logic [31:0] crc_in,
			input logic [7:0] data);
		logic [31:0] c;
		c = crc_in ^ {24'd0, data};
		for (int i = 0; i < 8; i++) begin
			c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
		end
		return c;
	endfunction

endpackage

// ===== hw/rtl/escaped_packet_deframer_crc32.sv =====
// ----------------------------------------------------------------------------
// escaped_packet_deframer_crc32
// Byte-stream deframer: finds escape-delimited packets, unmasks content,
// checks the trailing little-endian CRC-32 and reports packet events.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Signals                      Carries
//  s_*       in         tvalid tready tdata[7:0]     raw received byte
//  m_*       out        tvalid tready tdata[23:0]    content byte, reject count
//                       tuser[4:0]                   byte/event flags, event code
//  cfg_*     in         valid ready data[9:0]        max_content_len
//
// One byte is taken per cycle while m_tready is high; every byte gives exactly
// one result item. An accepted byte goes into the input register, then through
// the step logic and CRC byte update into the result register that drives m_*.
// Reset clears the frame state to hunting, the CRC to all ones, the reject
// count to zero and max_content_len to 249.
// A low m_tready holds the result register, then the input register; s_tready
// drops only when both are full and m_tready is low.
//
module escaped_packet_deframer_crc32 (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] in_byte
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata,   // [7:0] out_byte, [23:8] bad_packet_count
	output logic [4:0]  m_tuser,   // [0] byte_valid, [1] event_valid, [4:2] event_code
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [9:0]  cfg_data   // [9:0] max_content_len
);

	logic              valid_s1;
	logic [7:0]        byte_s1;
	logic              valid_s2;
	epd_pkg::result_t  result_s2;
	epd_pkg::state_t   state_q;
	epd_pkg::state_t   state_nxt;
	epd_pkg::result_t  result_nxt;
	logic [9:0]        max_len_q;
	logic              adv;

	// Advance stage 1 into the result register whenever that register frees up
	assign adv       = valid_s1 && (!valid_s2 || m_tready);
	assign s_tready  = !valid_s1 || adv;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_len_q <= epd_pkg::MAX_LEN_RST;
		end else if (cfg_valid) begin
			max_len_q <= cfg_data;
		end
	end

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			byte_s1 <= s_tdata;
		end
	end

	epd_step u_step (
		.cur             (state_q),
		.in_byte         (byte_s1),
		.max_content_len (max_len_q),
		.nxt             (state_nxt),
		.res             (result_nxt)
	);

	// Frame state: commit only when the byte moves on
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q.phase      <= epd_pkg::PH_HUNT;
			state_q.mask       <= 8'd0;
			state_q.bytes_seen <= 10'd0;
			state_q.tail       <= 32'd0;
			state_q.crc        <= epd_pkg::CRC_INIT;
			state_q.reject     <= 16'd0;
		end else if (adv) begin
			state_q <= state_nxt;
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (!valid_s2 || m_tready) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			result_s2 <= result_nxt;
		end
	end

	assign m_tvalid = valid_s2;
	assign m_tdata  = {result_s2.bad_packet_count, result_s2.out_byte};
	assign m_tuser  = {result_s2.event_code, result_s2.event_valid, result_s2.byte_valid};

	// A result never carries both a content byte and an event
	a_byte_xor_event: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> !(result_s2.byte_valid && result_s2.event_valid))
		else $error("content byte and event in one result");

	// Reject count never drops and steps by at most one
	a_reject_step: assert property (@(posedge clk) disable iff (!arst_n)
		##1 ((state_q.reject == $past(state_q.reject))
			|| (state_q.reject == $past(state_q.reject) + 16'd1)))
		else $error("reject count moved by more than one");

	// An overlong packet sends the framer back to hunting
	a_too_long_hunt: assert property (@(posedge clk) disable iff (!arst_n)
		(adv && result_nxt.event_valid && (result_nxt.event_code == epd_pkg::EV_TOO_LONG))
		|=> (state_q.phase == epd_pkg::PH_HUNT))
		else $error("framer not hunting after overlong packet");

	// A content byte only comes out of the payload phase
	a_byte_in_data: assert property (@(posedge clk) disable iff (!arst_n)
		(adv && result_nxt.byte_valid) |-> (state_q.phase == epd_pkg::PH_DATA))
		else $error("content byte outside payload");

endmodule

// ===== hw/rtl/epd_step.sv =====
// ----------------------------------------------------------------------------
// epd_step
// Next-state and result logic for one received byte: escape hunt, mask
// capture, four-byte delay, CRC update and end-of-packet checks.
// ----------------------------------------------------------------------------
module epd_step (
	input  epd_pkg::state_t  cur,
	input  logic [7:0]       in_byte,
	input  logic [9:0]       max_content_len,
	output epd_pkg::state_t  nxt,
	output epd_pkg::result_t res
);

	logic [10:0] limit;
	logic [10:0] limit_raw;
	logic [31:0] rx_crc;
	logic [7:0]  content;
	logic        count_bad;

	assign limit_raw = {1'b0, max_content_len} + {1'b0, epd_pkg::CRC_LEN};
	assign limit     = (limit_raw > epd_pkg::LEN_CAP) ? epd_pkg::LEN_CAP : limit_raw;
	// tail holds the newest byte low; the CRC travels little-endian
	assign rx_crc    = {cur.tail[7:0], cur.tail[15:8], cur.tail[23:16], cur.tail[31:24]}
			^ {4{cur.mask}};
	assign content   = cur.tail[31:24] ^ cur.mask;

	always_comb begin
		nxt                  = cur;
		res.byte_valid       = 1'b0;
		res.out_byte         = 8'd0;
		res.event_valid      = 1'b0;
		res.event_code       = epd_pkg::EV_GOOD;
		count_bad            = 1'b0;
		case (cur.phase)
			epd_pkg::PH_ESC: begin
				if (in_byte == epd_pkg::ESC_BYTE) begin
					nxt.phase = epd_pkg::PH_ESC;
				end else if (in_byte == epd_pkg::END_BYTE) begin
					res.event_valid = 1'b1;
					res.event_code  = epd_pkg::EV_END_MARK;
					nxt.phase       = epd_pkg::PH_HUNT;
				end else begin
					nxt.mask       = in_byte;
					nxt.bytes_seen = 10'd0;
					nxt.tail       = 32'd0;
					nxt.crc        = epd_pkg::CRC_INIT;
					nxt.phase      = epd_pkg::PH_DATA;
				end
			end
			epd_pkg::PH_DATA: begin
				if (in_byte == epd_pkg::ESC_BYTE) begin
					res.event_valid = 1'b1;
					if (cur.bytes_seen < epd_pkg::CRC_LEN) begin
						res.event_code = epd_pkg::EV_TOO_SHORT;
						count_bad      = 1'b1;
					end else if ((cur.crc ^ epd_pkg::CRC_INIT) == rx_crc) begin
						res.event_code = epd_pkg::EV_GOOD;
					end else begin
						res.event_code = epd_pkg::EV_CRC_BAD;
						count_bad      = 1'b1;
					end
					// this escape also opens the next frame
					nxt.phase = epd_pkg::PH_ESC;
				end else if ({1'b0, cur.bytes_seen} >= limit) begin
					res.event_valid = 1'b1;
					res.event_code  = epd_pkg::EV_TOO_LONG;
					count_bad       = 1'b1;
					nxt.phase       = epd_pkg::PH_HUNT;
				end else begin
					if (cur.bytes_seen >= epd_pkg::CRC_LEN) begin
						res.byte_valid = 1'b1;
						res.out_byte   = content;
						nxt.crc        = epd_pkg::crc_byte(cur.crc, content);
					end
					nxt.tail       = {cur.tail[23:0], in_byte};
					nxt.bytes_seen = cur.bytes_seen + 10'd1;
				end
			end
			default: begin
				nxt.phase = (in_byte == epd_pkg::ESC_BYTE) ? epd_pkg::PH_ESC
						: epd_pkg::PH_HUNT;
			end
		endcase
		if (count_bad && (cur.reject != epd_pkg::REJECT_MAX)) begin
			nxt.reject = cur.reject + 16'd1;
		end
		res.bad_packet_count = nxt.reject;
	end

endmodule

// ===== tb/deframer_checker.sv =====
// ----------------------------------------------------------------------------
// deframer_checker
// Watches the byte, result and register channels of the escaped packet
// deframer, predicts one result item per accepted byte and compares them.
// ----------------------------------------------------------------------------
module deframer_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] in_byte
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [23:0] m_tdata,   // [7:0] out_byte, [23:8] bad_packet_count
	input  logic [4:0]  m_tuser,   // [0] byte_valid, [1] event_valid, [4:2] event_code
	input  logic        cfg_valid,
	input  logic        cfg_ready,
	input  logic [9:0]  cfg_data,  // [9:0] max_content_len
	output int          mismatches,
	output int          outstanding
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int REPORT_MAX = 200;

	logic [9:0]        max_len;
	epd_pkg::phase_t   phase;
	logic [7:0]        mask;
	logic [9:0]        seen;
	logic [31:0]       tail;
	logic [31:0]       crc;
	logic [15:0]       rejects;
	int                errs;
	epd_pkg::result_t  predicted_results[$];

	// Reflected CRC-32, one data bit per step, lowest bit first
	function automatic logic [31:0] crc32_update(input logic [31:0] crc_in,
			input logic [7:0] data);
		logic [31:0] c;
		c = crc_in;
		for (int k = 0; k < 8; k++) begin
			if (c[0] ^ data[k]) begin
				c = {1'b0, c[31:1]} ^ epd_pkg::CRC_POLY;
			end else begin
				c = {1'b0, c[31:1]};
			end
		end
		return c;
	endfunction

	function automatic void count_reject();
		if (rejects != epd_pkg::REJECT_MAX) begin
			rejects++;
		end
	endfunction

	// Advance the deframer state by one raw byte and return the result item
	function automatic epd_pkg::result_t deframe_byte(input logic [7:0] b);
		epd_pkg::result_t r;
		logic [10:0]      limit;
		logic [7:0]       plain;
		logic [31:0]      rx_crc;
		r = '0;
		case (phase)
			epd_pkg::PH_ESC: begin
				if (b == epd_pkg::END_BYTE) begin
					r.event_valid = 1'b1;
					r.event_code  = epd_pkg::EV_END_MARK;
					phase         = epd_pkg::PH_HUNT;
				end else if (b != epd_pkg::ESC_BYTE) begin
					mask  = b;
					seen  = '0;
					tail  = '0;
					crc   = epd_pkg::CRC_INIT;
					phase = epd_pkg::PH_DATA;
				end
			end
			epd_pkg::PH_DATA: begin
				if (b == epd_pkg::ESC_BYTE) begin
					r.event_valid = 1'b1;
					if (seen < epd_pkg::CRC_LEN) begin
						r.event_code = epd_pkg::EV_TOO_SHORT;
						count_reject();
					end else begin
						// trailer is little endian, oldest tail byte lowest
						rx_crc = {tail[7:0], tail[15:8], tail[23:16], tail[31:24]}
								^ {4{mask}};
						if (~crc == rx_crc) begin
							r.event_code = epd_pkg::EV_GOOD;
						end else begin
							r.event_code = epd_pkg::EV_CRC_BAD;
							count_reject();
						end
					end
					phase = epd_pkg::PH_ESC;
				end else begin
					limit = {1'b0, max_len} + epd_pkg::CRC_LEN;
					if (limit > epd_pkg::LEN_CAP) begin
						limit = epd_pkg::LEN_CAP;
					end
					if ({1'b0, seen} >= limit) begin
						r.event_valid = 1'b1;
						r.event_code  = epd_pkg::EV_TOO_LONG;
						count_reject();
						phase = epd_pkg::PH_HUNT;
					end else begin
						if (seen >= epd_pkg::CRC_LEN) begin
							plain      = tail[31:24] ^ mask;
							r.byte_valid = 1'b1;
							r.out_byte   = plain;
							crc        = crc32_update(crc, plain);
						end
						tail = {tail[23:0], b};
						seen = seen + 10'd1;
					end
				end
			end
			default: begin
				phase = (b == epd_pkg::ESC_BYTE) ? epd_pkg::PH_ESC : epd_pkg::PH_HUNT;
			end
		endcase
		r.bad_packet_count = rejects;
		return r;
	endfunction

	task automatic check_field(input string name, input int unsigned want,
			input int unsigned got);
		if (want != got) begin
			errs++;
			// keep the log bounded when the block is badly off
			if (errs <= REPORT_MAX) begin
				$display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h",
						$time, name, want, got);
			end
		end
	endtask

	task automatic compare_result(input epd_pkg::result_t want);
		check_field("byte_valid", want.byte_valid, m_tuser[0]);
		check_field("out_byte", want.out_byte, m_tdata[7:0]);
		check_field("event_valid", want.event_valid, m_tuser[1]);
		check_field("event_code", want.event_code, m_tuser[4:2]);
		check_field("bad_packet_count", want.bad_packet_count, m_tdata[23:8]);
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_len = epd_pkg::MAX_LEN_RST;
			phase   = epd_pkg::PH_HUNT;
			mask    = '0;
			seen    = '0;
			tail    = '0;
			crc     = epd_pkg::CRC_INIT;
			rejects = '0;
			errs    = 0;
			predicted_results.delete();
			mismatches  <= 0;
			outstanding <= 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				max_len = cfg_data;
			end
			// a result never leaves at the edge that accepts its byte, so compare first
			if (m_tvalid && m_tready) begin
				if (predicted_results.size() == 0) begin
					errs++;
					if (errs <= REPORT_MAX) begin
						$display("%0t: result item with none expected, actual 0x%0h/0x%0h",
								$time, m_tuser, m_tdata);
					end
				end else begin
					compare_result(predicted_results.pop_front());
				end
			end
			if (s_tvalid && s_tready) begin
				predicted_results.push_back(deframe_byte(s_tdata));
			end
			mismatches  <= errs;
			outstanding <= predicted_results.size();
		end
	end

endmodule

// ===== tb/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Drives framed byte streams into the escaped packet deframer: a directed
// opening, random packets at several payload limits and a packet that runs
// past the capped largest limit. Both stream sides idle at random; a checker
// beside the block predicts and compares.
// ----------------------------------------------------------------------------
module testbench;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int LONG_HOLD  = 400;    // cycles of receiver hold-off
	localparam int TAIL_WAIT  = 20;     // quiet cycles before the verdict

	logic        clk       = 1'b0;
	logic        arst_n    = 1'b0;
	logic        s_tvalid  = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata   = '0;
	logic        m_tvalid;
	logic        m_tready  = 1'b0;
	logic [23:0] m_tdata;
	logic [4:0]  m_tuser;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [9:0]  cfg_data  = '0;

	int mismatches;
	int outstanding;

	logic [7:0] tx_q[$];       // raw bytes waiting to go out
	int         bytes_sent = 0;
	int         cur_max    = epd_pkg::MAX_LEN_RST;
	bit         src_idle   = 1'b0;
	bit         sink_idle  = 1'b0;
	bit         long_hold  = 1'b0;

	always #4 clk = ~clk;

	escaped_packet_deframer_crc32 u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	deframer_checker u_chk (
		.clk         (clk),
		.arst_n      (arst_n),
		.s_tvalid    (s_tvalid),
		.s_tready    (s_tready),
		.s_tdata     (s_tdata),
		.m_tvalid    (m_tvalid),
		.m_tready    (m_tready),
		.m_tdata     (m_tdata),
		.m_tuser     (m_tuser),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_data    (cfg_data),
		.mismatches  (mismatches),
		.outstanding (outstanding)
	);

	// Mostly short gaps, now and then a long one; never zero
	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 9);
		if (r < 6) begin
			return $urandom_range(1, 2);
		end else if (r < 9) begin
			return $urandom_range(3, 6);
		end
		return $urandom_range(15, 40);
	endfunction

	// A mask byte must not read as another escape or as the end marker
	function automatic logic [7:0] pick_mask();
		logic [7:0] m;
		do begin
			m = 8'($urandom);
		end while (m == epd_pkg::ESC_BYTE || m == epd_pkg::END_BYTE);
		return m;
	endfunction

	// Queue one frame: escape, mask, masked content, masked little-endian CRC.
	// The frame is closed by whatever escape follows it.
	task automatic put_frame(input logic [7:0] mask, input int n, input bit corrupt);
		logic [31:0] crc;
		logic [7:0]  c;
		crc = epd_pkg::CRC_INIT;
		tx_q.push_back(epd_pkg::ESC_BYTE);
		tx_q.push_back(mask);
		for (int i = 0; i < n; i++) begin
			c = 8'($urandom);
			// keep the raw byte off the escape value
			if ((c ^ mask) == epd_pkg::ESC_BYTE) begin
				c = ~c;
			end
			crc = epd_pkg::crc_byte(crc, c);
			tx_q.push_back(c ^ mask);
		end
		crc = ~crc;
		if (corrupt) begin
			crc ^= 32'd1 << $urandom_range(0, 31);
		end
		for (int k = 0; k < 4; k++) begin
			tx_q.push_back(crc[8*k +: 8] ^ mask);
		end
	endtask

	// Offer one byte, with an optional gap first; return at the accepting edge
	task automatic send_byte(input logic [7:0] b);
		int gap;
		gap = (src_idle && $urandom_range(0, 1) == 1) ? gap_len() : 0;
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= b;
		do @(posedge clk); while (!s_tready);
		bytes_sent++;
	endtask

	task automatic flush_tx();
		while (tx_q.size() > 0) begin
			send_byte(tx_q.pop_front());
		end
	endtask

	// Drop valid, drain every expected item, then write max_content_len
	task automatic write_max_len(input logic [9:0] v);
		s_tvalid <= 1'b0;
		do @(posedge clk); while (outstanding != 0);
		cfg_valid <= 1'b1;
		cfg_data  <= v;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		cur_max = v;
	endtask

	// Mostly well-formed packets with random content and length; the rest
	// corrupted trailers, end markers, cut-off packets and raw noise.
	task automatic random_traffic(input int budget);
		int stop;
		int cap;
		int r;
		stop = bytes_sent + budget;
		// lengths stay small; near a small limit some packets run too long
		cap  = (cur_max < 30) ? cur_max + 2 : 30;
		while (bytes_sent < stop) begin
			if ($urandom_range(0, 3) == 0) begin
				src_idle = !src_idle;
			end
			if ($urandom_range(0, 3) == 0) begin
				sink_idle = !sink_idle;
			end
			r = $urandom_range(0, 99);
			if (r < 65) begin
				put_frame(pick_mask(), $urandom_range(0, cap), 1'b0);
			end else if (r < 77) begin
				put_frame(pick_mask(), $urandom_range(0, cap), 1'b1);
			end else if (r < 84) begin
				tx_q.push_back(epd_pkg::ESC_BYTE);
				tx_q.push_back(epd_pkg::END_BYTE);
			end else if (r < 91) begin
				// packet cut off before its trailer is complete
				tx_q.push_back(epd_pkg::ESC_BYTE);
				tx_q.push_back(pick_mask());
				repeat ($urandom_range(0, 3)) tx_q.push_back(8'($urandom));
			end else begin
				repeat ($urandom_range(1, 8)) begin
					tx_q.push_back(($urandom_range(0, 3) == 0) ? epd_pkg::ESC_BYTE
							: 8'($urandom));
				end
			end
			flush_tx();
		end
		// close the last packet and leave the block hunting
		tx_q.push_back(epd_pkg::ESC_BYTE);
		tx_q.push_back(epd_pkg::END_BYTE);
		flush_tx();
	endtask

	// Receiver: random stalls while sink_idle is set, one long hold-off on request
	initial begin : sink
		forever begin
			if (long_hold) begin
				m_tready <= 1'b0;
				repeat (LONG_HOLD) @(posedge clk);
				long_hold = 1'b0;
			end else if (sink_idle && $urandom_range(0, 2) == 0) begin
				m_tready <= 1'b0;
				repeat (gap_len()) @(posedge clk);
			end else begin
				m_tready <= 1'b1;
				@(posedge clk);
			end
		end
	end

	initial begin : stimulus
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed opening at the reset limit: junk while hunting, end marker,
		// repeated escape, good packet whose closing escape opens the next
		// frame, too-short packet, CRC mismatch, end marker.
		tx_q.push_back(8'h00);
		tx_q.push_back(8'hFF);
		tx_q.push_back(epd_pkg::ESC_BYTE);
		tx_q.push_back(epd_pkg::END_BYTE);
		tx_q.push_back(epd_pkg::ESC_BYTE);
		tx_q.push_back(epd_pkg::ESC_BYTE);
		put_frame(8'h00, 1, 1'b0);
		tx_q.push_back(epd_pkg::ESC_BYTE);
		tx_q.push_back(8'h5A);
		repeat (3) tx_q.push_back(8'($urandom_range(0, 255)));
		put_frame(8'h11, 2, 1'b1);
		tx_q.push_back(epd_pkg::ESC_BYTE);
		tx_q.push_back(epd_pkg::END_BYTE);
		flush_tx();

		// Hold off the receiver for a long stretch while bytes keep coming
		long_hold = 1'b1;
		random_traffic(300);

		// Smallest limit: an empty packet passes, one content byte is too long
		write_max_len(10'd0);
		put_frame(pick_mask(), 0, 1'b0);
		put_frame(pick_mask(), 1, 1'b0);
		random_traffic(100);

		// Above 1019 the payload limit saturates at 1023 bytes, so 1020
		// content bytes plus the trailer run one byte too long
		write_max_len(10'd1023);
		put_frame(pick_mask(), 1020, 1'b0);
		flush_tx();
		random_traffic(60);

		repeat (2) begin
			write_max_len(10'($urandom_range(1, 40)));
			random_traffic(60);
		end

		s_tvalid <= 1'b0;
		do @(posedge clk); while (outstanding != 0);
		repeat (TAIL_WAIT) @(posedge clk);
		if (mismatches == 0 && outstanding == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

	initial begin : watchdog
		#10ms;
		$display("FAIL");
		$finish;
	end

endmodule

// ===== filelist.f =====
hw/rtl/epd_pkg.sv
hw/rtl/epd_step.sv
hw/rtl/escaped_packet_deframer_crc32.sv
tb/deframer_checker.sv
tb/testbench.sv
